// File: hdl/rrmq_pkg.sv
// ----------------------------------------------------------------------------
// rrmq_pkg
// Shared constants, codes and types of the round-robin multi-queue.
// ----------------------------------------------------------------------------
`default_nettype none

package rrmq_pkg;

   // Default sizing of the store
   localparam int unsigned DEFAULT_KEYS     = 64;
   localparam int unsigned DEFAULT_CAPACITY = 1024;

   // Fixed payload widths
   localparam int unsigned KEY_WIDTH    = 6;
   localparam int unsigned VALUE_WIDTH  = 16;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned KEY_CODES    = 2 ** KEY_WIDTH;

   // Command codes
   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_TAKE    = 1'b1;

   // Result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL  = 2'd2;

   // Update of the nonempty flags and the round-robin pointer
   typedef struct packed {
      logic set_en;     // mark the enqueue key nonempty
      logic clear_en;   // mark the served key empty
      logic served_en;  // move the pointer to the served key
      logic rewind;     // store drained: pointer back to the last key
   } rrmq_flag_op_type;

endpackage

`default_nettype wire

// File: hdl/rrmq_channels.sv
// ----------------------------------------------------------------------------
// rrmq_channels
// Valid/ready channels for commands and results of the multi-queue.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrmq_req_if
   import rrmq_pkg::*;
();
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [KEY_WIDTH-1:0]   key;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink (input valid, input command, input key, input value, output ready);
endinterface

interface rrmq_rsp_if
   import rrmq_pkg::*;
();
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic [KEY_WIDTH-1:0]    out_key;
   logic [VALUE_WIDTH-1:0]  out_value;
   logic                    drained;

   modport source (output valid, output status, output out_key, output out_value,
                   output drained, input ready);
   modport sink (input valid, input status, input out_key, input out_value,
                 input drained, output ready);
endinterface

`default_nettype wire

// File: hdl/rrmq_queue_mem.sv
// ----------------------------------------------------------------------------
// rrmq_queue_mem
// Head and tail slot of each key's queue, registered synchronous read.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmq_queue_mem
   import rrmq_pkg::*;
#(
   parameter int unsigned KEYS     = DEFAULT_KEYS,
   parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                        clock,
   input  wire logic                        head_we,
   input  wire logic                        tail_we,
   input  wire logic [$clog2(KEYS)-1:0]     waddr,
   input  wire logic [$clog2(CAPACITY)-1:0] head_wdata,
   input  wire logic [$clog2(CAPACITY)-1:0] tail_wdata,
   input  wire logic                        re,
   input  wire logic [$clog2(KEYS)-1:0]     raddr,
   output      logic [$clog2(CAPACITY)-1:0] head_rdata,
   output      logic [$clog2(CAPACITY)-1:0] tail_rdata
);
   localparam int unsigned SW = $clog2(CAPACITY);

   logic [SW-1:0] head_mem [KEYS];
   logic [SW-1:0] tail_mem [KEYS];
   logic [SW-1:0] head_rdata_ff;
   logic [SW-1:0] tail_rdata_ff;

   // Write and read both tables at one address each
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[waddr] <= head_wdata;
      end
      if (tail_we) begin
         tail_mem[waddr] <= tail_wdata;
      end
      if (re) begin
         head_rdata_ff <= head_mem[raddr];
         tail_rdata_ff <= tail_mem[raddr];
      end
   end

   assign head_rdata = head_rdata_ff;
   assign tail_rdata = tail_rdata_ff;

endmodule

`default_nettype wire

// File: hdl/rrmq_slot_mem.sv
// ----------------------------------------------------------------------------
// rrmq_slot_mem
// Shared slot store: link to the next slot and stored value per slot.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmq_slot_mem
   import rrmq_pkg::*;
#(
   parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                        clock,
   input  wire logic                        link_we,
   input  wire logic [$clog2(CAPACITY)-1:0] link_waddr,
   input  wire logic [$clog2(CAPACITY)-1:0] link_wdata,
   input  wire logic                        value_we,
   input  wire logic [$clog2(CAPACITY)-1:0] value_waddr,
   input  wire logic [VALUE_WIDTH-1:0]      value_wdata,
   input  wire logic                        re,
   input  wire logic [$clog2(CAPACITY)-1:0] raddr,
   output      logic [$clog2(CAPACITY)-1:0] link_rdata,
   output      logic [VALUE_WIDTH-1:0]      value_rdata
);
   localparam int unsigned SW = $clog2(CAPACITY);

   logic [SW-1:0]          link_mem  [CAPACITY];
   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
   logic [SW-1:0]          link_rdata_ff;
   logic [VALUE_WIDTH-1:0] value_rdata_ff;

   // Write link and value independently, read both at one slot
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (value_we) begin
         value_mem[value_waddr] <= value_wdata;
      end
      if (re) begin
         link_rdata_ff  <= link_mem[raddr];
         value_rdata_ff <= value_mem[raddr];
      end
   end

   assign link_rdata  = link_rdata_ff;
   assign value_rdata = value_rdata_ff;

endmodule

`default_nettype wire

// File: hdl/rrmq_pick.sv
// ----------------------------------------------------------------------------
// rrmq_pick
// Nonempty flag per key, round-robin pointer and the next-key search.
// ----------------------------------------------------------------------------
`default_nettype none

module rrmq_pick
   import rrmq_pkg::*;
#(
   parameter int unsigned KEYS = DEFAULT_KEYS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rrmq_flag_op_type        op,
   input  wire logic [$clog2(KEYS)-1:0] set_key,
   input  wire logic [$clog2(KEYS)-1:0] clear_key,
   input  wire logic [$clog2(KEYS)-1:0] served_key,
   input  wire logic [$clog2(KEYS)-1:0] query_key,
   output      logic                    query_hit,
   output      logic [$clog2(KEYS)-1:0] pick
);
   localparam int unsigned KW = $clog2(KEYS);

   logic [KEYS-1:0] nonempty_ff;
   logic [KEYS-1:0] nonempty_in;
   logic [KW-1:0]   last_served_ff;
   logic [KW-1:0]   last_served_in;
   logic [KW-1:0]   pick_upper;
   logic [KW-1:0]   pick_lower;
   logic            upper_found;

   // Apply flag and pointer updates
   always_comb begin
      nonempty_in    = nonempty_ff;
      last_served_in = last_served_ff;
      if (op.clear_en) begin
         nonempty_in[clear_key] = 1'b0;
      end
      if (op.set_en) begin
         nonempty_in[set_key] = 1'b1;
      end
      if (op.served_en) begin
         last_served_in = op.rewind ? KW'(KEYS - 1) : served_key;
      end
   end

   // Find the lowest nonempty key above the pointer, else the lowest overall
   always_comb begin
      pick_upper  = '0;
      pick_lower  = '0;
      upper_found = 1'b0;
      for (int i = KEYS - 1; i >= 0; i--) begin
         if (nonempty_ff[i] && (KW'(i) > last_served_ff)) begin
            pick_upper  = KW'(i);
            upper_found = 1'b1;
         end
         if (nonempty_ff[i]) begin
            pick_lower = KW'(i);
         end
      end
   end

   assign pick      = upper_found ? pick_upper : pick_lower;
   assign query_hit = nonempty_ff[query_key];

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff    <= '0;
         last_served_ff <= KW'(KEYS - 1);
      end else begin
         nonempty_ff    <= nonempty_in;
         last_served_ff <= last_served_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/round_robin_multi_queue.sv
// ----------------------------------------------------------------------------
// round_robin_multi_queue
// Per-key FIFO queues in a shared linked store with a round-robin drain.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries commands: enqueue appends value to the queue of key
//   (key taken modulo KEYS); take pops the oldest value of the next
//   nonempty key after the last one served, in ascending key order.
//   rsp_chan returns one result per command: status (done, empty, full),
//   out_key and out_value of a taken item, and drained when the store is
//   left holding nothing.
//   An enqueue or a take on an empty store goes from idle straight to commit;
//   a take that pops an item passes through a lookup state in between.
//   One command is in flight at a time: a new command transfers only in
//   idle; a take that pops needs the lookup state because its slot address
//   comes out of the head table before the slot store can be read.
//   Results sit in an output register, so the next command transfers while
//   a result waits; if the receiver stalls, the following command holds in
//   its commit state, without touching any memory, until the register frees.
//   Reset clears the nonempty flags, free list, counters and pointer; the
//   tables hold no reset value and their data is only used where written.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_multi_queue
   import rrmq_pkg::*;
#(
   parameter int unsigned KEYS     = DEFAULT_KEYS,
   parameter int unsigned CAPACITY = DEFAULT_CAPACITY
) (
   input wire logic  clock,
   input wire logic  reset,
   rrmq_req_if.sink   req_chan,
   rrmq_rsp_if.source rsp_chan
);
   localparam int unsigned KW = $clog2(KEYS);
   localparam int unsigned SW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_COMMIT
   } state_type;

   state_type state_ff, state_in;

   // Command registers
   logic                    cmd_ff, cmd_in;
   logic [KW-1:0]           key_ff, key_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    key_busy_ff, key_busy_in;
   logic [KW-1:0]           pick_ff, pick_in;
   logic                    empty_ff, empty_in;
   logic [SW-1:0]           slot_ff, slot_in;
   logic                    last_ff, last_in;

   // Free list and counters
   logic [SW-1:0]           free_head_ff, free_head_in;
   logic                    free_valid_ff, free_valid_in;
   logic [CW-1:0]           fresh_count_ff, fresh_count_in;
   logic [CW-1:0]           items_held_ff, items_held_in;

   // Result register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [KEY_WIDTH-1:0]    out_key_ff, out_key_in;
   logic [VALUE_WIDTH-1:0]  out_value_ff, out_value_in;
   logic                    drained_ff, drained_in;

   // Memory ports
   logic                    q_head_we, q_tail_we, q_re;
   logic [KW-1:0]           q_waddr, q_raddr;
   logic [SW-1:0]           q_head_wdata, q_tail_wdata;
   logic [SW-1:0]           head_rdata, tail_rdata;
   logic                    s_link_we, s_value_we, s_re;
   logic [SW-1:0]           s_link_waddr, s_link_wdata, s_value_waddr, s_raddr;
   logic [VALUE_WIDTH-1:0]  s_value_wdata;
   logic [SW-1:0]           link_rdata;
   logic [VALUE_WIDTH-1:0]  value_rdata;

   // Flag and pointer unit
   rrmq_flag_op_type        flag_op;
   logic                    query_hit;
   logic [KW-1:0]           pick;

   logic                    req_fire;
   logic                    rsp_free;
   logic                    store_full;
   logic [SW-1:0]           new_slot;
   logic [KW-1:0]           req_key;
   logic [KW-1:0]           key_map [KEY_CODES];
   logic [KW+KEY_WIDTH-1:0] pick_wide;

   // Reduce the key code modulo KEYS through a constant table
   for (genvar i = 0; i < KEY_CODES; i++) begin : g_key_map
      localparam int unsigned KEY_MOD = i % KEYS;
      assign key_map[i] = KW'(KEY_MOD);
   end

   assign req_key    = key_map[req_chan.key];
   assign req_fire   = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign store_full = !free_valid_ff && (fresh_count_ff == CW'(CAPACITY));
   assign new_slot   = free_valid_ff ? free_head_ff : fresh_count_ff[SW-1:0];
   assign pick_wide  = {{KEY_WIDTH{1'b0}}, pick_ff};

   rrmq_queue_mem #(
      .KEYS     (KEYS),
      .CAPACITY (CAPACITY)
   ) u_queue_mem (
      .clock      (clock),
      .head_we    (q_head_we),
      .tail_we    (q_tail_we),
      .waddr      (q_waddr),
      .head_wdata (q_head_wdata),
      .tail_wdata (q_tail_wdata),
      .re         (q_re),
      .raddr      (q_raddr),
      .head_rdata (head_rdata),
      .tail_rdata (tail_rdata)
   );

   rrmq_slot_mem #(
      .CAPACITY (CAPACITY)
   ) u_slot_mem (
      .clock       (clock),
      .link_we     (s_link_we),
      .link_waddr  (s_link_waddr),
      .link_wdata  (s_link_wdata),
      .value_we    (s_value_we),
      .value_waddr (s_value_waddr),
      .value_wdata (s_value_wdata),
      .re          (s_re),
      .raddr       (s_raddr),
      .link_rdata  (link_rdata),
      .value_rdata (value_rdata)
   );

   rrmq_pick #(
      .KEYS (KEYS)
   ) u_pick (
      .clock      (clock),
      .reset      (reset),
      .op         (flag_op),
      .set_key    (key_ff),
      .clear_key  (pick_ff),
      .served_key (pick_ff),
      .query_key  (req_key),
      .query_hit  (query_hit),
      .pick       (pick)
   );

   // Sequence each command: read, optional second read, then commit
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      key_busy_in    = key_busy_ff;
      pick_in        = pick_ff;
      empty_in       = empty_ff;
      slot_in        = slot_ff;
      last_in        = last_ff;
      free_head_in   = free_head_ff;
      free_valid_in  = free_valid_ff;
      fresh_count_in = fresh_count_ff;
      items_held_in  = items_held_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      status_in      = status_ff;
      out_key_in     = out_key_ff;
      out_value_in   = out_value_ff;
      drained_in     = drained_ff;

      q_head_we      = 1'b0;
      q_tail_we      = 1'b0;
      q_waddr        = key_ff;
      q_head_wdata   = new_slot;
      q_tail_wdata   = new_slot;
      q_re           = 1'b0;
      q_raddr        = req_key;
      s_link_we      = 1'b0;
      s_link_waddr   = tail_rdata;
      s_link_wdata   = new_slot;
      s_value_we     = 1'b0;
      s_value_waddr  = new_slot;
      s_value_wdata  = value_ff;
      s_re           = 1'b0;
      s_raddr        = free_head_ff;
      flag_op        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in      = req_chan.command;
               key_in      = req_key;
               value_in    = req_chan.value;
               key_busy_in = query_hit;
               pick_in     = pick;
               empty_in    = (items_held_ff == '0);
               // Head/tail at the key or the picked key, link at the free head
               q_re        = 1'b1;
               q_raddr     = (req_chan.command == CMD_TAKE) ? pick : req_key;
               s_re        = 1'b1;
               s_raddr     = free_head_ff;
               if (req_chan.command == CMD_TAKE && items_held_ff != '0) begin
                  state_in = ST_LOOKUP;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end

         ST_LOOKUP: begin
            // Read link and value of the oldest slot of the picked key
            s_re     = 1'b1;
            s_raddr  = head_rdata;
            slot_in  = head_rdata;
            last_in  = (head_rdata == tail_rdata);
            state_in = ST_COMMIT;
         end

         ST_COMMIT: begin
            if (rsp_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               out_key_in   = '0;
               out_value_in = '0;
               status_in    = STATUS_DONE;
               if (cmd_ff == CMD_ENQUEUE) begin
                  if (store_full) begin
                     status_in = STATUS_FULL;
                  end else begin
                     // Allocate from the free list, else a fresh slot
                     if (free_valid_ff) begin
                        free_head_in = link_rdata;
                     end else begin
                        fresh_count_in = fresh_count_ff + CW'(1);
                     end
                     items_held_in = items_held_ff + CW'(1);
                     s_value_we    = 1'b1;
                     s_value_waddr = new_slot;
                     s_value_wdata = value_ff;
                     // Chain behind the current tail, or start the queue
                     if (key_busy_ff) begin
                        s_link_we    = 1'b1;
                        s_link_waddr = tail_rdata;
                        s_link_wdata = new_slot;
                     end else begin
                        q_head_we    = 1'b1;
                        q_head_wdata = new_slot;
                     end
                     q_tail_we      = 1'b1;
                     q_tail_wdata   = new_slot;
                     q_waddr        = key_ff;
                     flag_op.set_en = 1'b1;
                  end
               end else if (empty_ff) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  out_key_in   = pick_wide[KEY_WIDTH-1:0];
                  out_value_in = value_rdata;
                  // Pop the head: drop the queue or advance its head
                  q_waddr      = pick_ff;
                  if (last_ff) begin
                     flag_op.clear_en = 1'b1;
                  end else begin
                     q_head_we    = 1'b1;
                     q_head_wdata = link_rdata;
                  end
                  // Push the slot onto the free list
                  s_link_we         = 1'b1;
                  s_link_waddr      = slot_ff;
                  s_link_wdata      = free_head_ff;
                  free_head_in      = slot_ff;
                  items_held_in     = items_held_ff - CW'(1);
                  flag_op.served_en = 1'b1;
                  flag_op.rewind    = (items_held_in == '0);
               end
               free_valid_in = (fresh_count_in != items_held_in);
               drained_in    = (items_held_in == '0);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         free_head_ff   <= '0;
         free_valid_ff  <= 1'b0;
         fresh_count_ff <= '0;
         items_held_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         free_valid_ff  <= free_valid_in;
         fresh_count_ff <= fresh_count_in;
         items_held_ff  <= items_held_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      key_busy_ff  <= key_busy_in;
      pick_ff      <= pick_in;
      empty_ff     <= empty_in;
      slot_ff      <= slot_in;
      last_ff      <= last_in;
      status_ff    <= status_in;
      out_key_ff   <= out_key_in;
      out_value_ff <= out_value_in;
      drained_ff   <= drained_in;
   end

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = status_ff;
   assign rsp_chan.out_key   = out_key_ff;
   assign rsp_chan.out_value = out_value_ff;
   assign rsp_chan.drained   = drained_ff;

`ifndef ASSERT_OFF
   a_items_bounded: assert property (@(posedge clock) disable iff (reset)
      items_held_ff <= fresh_count_ff)
      else $error("items held exceed slots ever used");

   a_free_list_consistent: assert property (@(posedge clock) disable iff (reset)
      free_valid_ff == (fresh_count_ff != items_held_ff))
      else $error("free list flag disagrees with counters");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && cmd_ff == CMD_TAKE && !empty_ff) |-> items_held_ff != '0)
      else $error("pop committed on an empty store");

   a_lookup_to_commit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOOKUP |=> state_ff == ST_COMMIT)
      else $error("slot lookup not followed by commit");

   a_commit_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT && rsp_free) |=> (rsp_chan.valid && state_ff == ST_IDLE))
      else $error("commit did not load a result");
`endif

endmodule

`default_nettype wire
